>>> design/lsbi_pkg.sv
// Shared constants and codes for the LIFO stack with bottom insert.
`timescale 1ns / 1ps
`default_nettype none
package lsbi_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    FN_PUSH    = 3'd0,
    FN_POP     = 3'd1,
    FN_PEEK    = 3'd2,
    FN_INSERT  = 3'd3,
    FN_REVERSE = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage
`default_nettype wire

>>> design/lifo_stack_with_bottom_insert_unit.sv
// Top level of the LIFO stack with bottom insert, built around one entry memory.
`timescale 1ns / 1ps
`default_nettype none
// One request is taken at a time and each beat in gives exactly one beat out
// carrying data, status and the entry count after the request. The entries
// live in a single memory with one write port and one read port whose read
// data is registered. Push and refused or trivial requests finish in the
// cycle they are accepted; pop and peek pass through a read state for the
// registered memory read. Insert at bottom reads every held entry and
// writes it back one place higher through the single port pair, then
// writes the new value at the bottom. Reverse swaps pairs from both ends
// in states RV_HI, RV_SW, RV_WB and RV_LAST. A finished result waits in
// the output register, and a request can be accepted meanwhile; a second
// finished result is parked until the first one is taken.
module lifo_stack_with_bottom_insert_unit
  import lsbi_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  func,
  input  wire logic signed [WORD_BITS-1:0] value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [WORD_BITS-1:0]      data,
  output logic [1:0]                       status,
  output logic [CNT_W-1:0]                 count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_RV_HI,
    S_RV_SW,
    S_RV_WB,
    S_RV_LAST,
    S_HOLD
  } state_t;

  state_t state;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata;

  logic [CNT_W-1:0]     fill;
  logic [WORD_BITS-1:0] val;
  logic [WORD_BITS-1:0] tmp;
  logic [ADDR_W-1:0]    lo;
  logic [ADDR_W-1:0]    hi;
  logic [ADDR_W-1:0]    ptr;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 wr_pend;

  logic [WORD_BITS-1:0] h_data;
  status_t              h_status;
  logic [CNT_W-1:0]     h_count;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_raddr;

  logic                 fin;
  logic [WORD_BITS-1:0] fin_data;
  status_t              fin_status;
  logic [CNT_W-1:0]     fin_count;

  logic                 accept;
  logic                 is_full;
  logic                 is_empty;
  logic                 rv_more;
  logic                 out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_full  = (fill == CNT_W'(DEPTH));
  assign is_empty = (fill == '0);
  assign rv_more  = ((lo + ADDR_W'(1)) < (hi - ADDR_W'(1)));
  assign out_free = !out_valid || out_ready;

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = val;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    fin        = 1'b0;
    fin_data   = '0;
    fin_status = ST_OK;
    fin_count  = fill;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (func_t'(func))
            FN_PUSH: begin
              fin = 1'b1;
              if (is_full) begin
                fin_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = fill[ADDR_W-1:0];
                mem_wdata = value;
                fin_count = fill + CNT_W'(1);
              end
            end
            FN_POP: begin
              if (is_empty) begin
                fin        = 1'b1;
                fin_data   = '1;
                fin_status = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(fill - CNT_W'(1));
              end
            end
            FN_PEEK: begin
              if (is_empty) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(fill - CNT_W'(1));
              end
            end
            FN_INSERT: begin
              if (is_full) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end
            end
            FN_REVERSE: begin
              if (is_empty) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else if (fill == CNT_W'(1)) begin
                fin = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        fin      = 1'b1;
        fin_data = rdata;
      end
      S_SHIFT: begin
        if (wr_pend) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr;
          mem_wdata = rdata;
        end
        if (ptr != '0) begin
          mem_re    = 1'b1;
          mem_raddr = ptr - ADDR_W'(1);
        end else if (!wr_pend) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = val;
          fin       = 1'b1;
          fin_count = fill + CNT_W'(1);
        end
      end
      S_RV_HI: begin
        mem_re    = 1'b1;
        mem_raddr = hi;
      end
      S_RV_SW: begin
        mem_we    = 1'b1;
        mem_waddr = lo;
        mem_wdata = rdata;
        if (rv_more) begin
          mem_re    = 1'b1;
          mem_raddr = lo + ADDR_W'(1);
        end
      end
      S_RV_WB: begin
        mem_we    = 1'b1;
        mem_waddr = hi + ADDR_W'(1);
        mem_wdata = tmp;
        mem_re    = 1'b1;
        mem_raddr = hi;
      end
      S_RV_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = hi + ADDR_W'(1);
        mem_wdata = tmp;
        fin       = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
      wr_pend   <= 1'b0;
    end else begin
      if (out_valid && out_ready && !fin && (state != S_HOLD)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (func_t'(func))
              FN_PUSH: begin
                if (!is_full) begin
                  fill <= fill + CNT_W'(1);
                end
              end
              FN_POP: begin
                if (!is_empty) begin
                  fill  <= fill - CNT_W'(1);
                  state <= S_READ;
                end
              end
              FN_PEEK: begin
                if (!is_empty) begin
                  state <= S_READ;
                end
              end
              FN_INSERT: begin
                if (!is_full) begin
                  val     <= value;
                  ptr     <= fill[ADDR_W-1:0];
                  wr_pend <= 1'b0;
                  state   <= S_SHIFT;
                end
              end
              FN_REVERSE: begin
                if (fill > CNT_W'(1)) begin
                  lo    <= '0;
                  hi    <= ADDR_W'(fill - CNT_W'(1));
                  state <= S_RV_HI;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (ptr != '0) begin
            wr_pend <= 1'b1;
            wr_addr <= ptr;
            ptr     <= ptr - ADDR_W'(1);
          end else begin
            wr_pend <= 1'b0;
            if (!wr_pend) begin
              fill <= fill + CNT_W'(1);
            end
          end
        end
        S_RV_HI: begin
          tmp   <= rdata;
          state <= S_RV_SW;
        end
        S_RV_SW: begin
          lo    <= lo + ADDR_W'(1);
          hi    <= hi - ADDR_W'(1);
          state <= rv_more ? S_RV_WB : S_RV_LAST;
        end
        S_RV_WB: begin
          tmp   <= rdata;
          state <= S_RV_SW;
        end
        S_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b1;
            data      <= h_data;
            status    <= h_status;
            count     <= h_count;
            state     <= S_IDLE;
          end
        end
        default: begin
        end
      endcase
      if (fin) begin
        if (out_free) begin
          out_valid <= 1'b1;
          data      <= fin_data;
          status    <= fin_status;
          count     <= fin_count;
          state     <= S_IDLE;
        end else begin
          h_data   <= fin_data;
          h_status <= fin_status;
          h_count  <= fin_count;
          state    <= S_HOLD;
        end
      end
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("Entry count exceeds the stack depth.");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (count == CNT_W'(DEPTH)))
    else $error("Full status reported while the stack is not full.");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (count == '0))
    else $error("Empty status reported with entries held.");

  a_hold_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> (!mem_we && !in_ready))
    else $error("Memory written or request taken while a result is parked.");

endmodule
`default_nettype wire
